@@ src/sbs_pkg.sv @@
package sbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int POS_W       = 10;
    localparam int DATA_W      = 32;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic                     command;
        logic [POS_W-1:0]         entry_position;
        logic signed [DATA_W-1:0] entry_or_key;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
    } out_item_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

@@ src/sbs_table_ram.sv @@
module sbs_table_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/sbs_search_ctrl.sv @@
module sbs_search_ctrl
    import sbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  in_item_t          item,
    output logic              done,
    output out_item_t         result,
    input  logic              cfg_write,
    input  logic [COUNT_W-1:0] cfg_data,
    output ram_req_t          ram_req,
    input  logic [DATA_W-1:0] ram_rdata
);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_PROBE   = 3'b010,
        ST_COMPARE = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   lo_reg, lo_next;
    logic [COUNT_W-1:0]   hi_reg, hi_next;   // exclusive upper bound
    logic [ADDR_W-1:0]    mid_reg, mid_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic                 done_reg, done_next;
    out_item_t            result_reg, result_next;

    logic                 accept;
    logic [COUNT_W-1:0]   limit;
    logic [COUNT_W-1:0]   span;
    logic [COUNT_W-1:0]   mid_wide;
    logic [COUNT_W-1:0]   mid_ext;
    logic [COUNT_W-1:0]   mid_plus;
    logic signed [DATA_W-1:0] probe;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign limit  = (count_reg > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : count_reg;

    // Midpoint of the current window: lo + (hi - 1 - lo) / 2
    assign span     = hi_reg - lo_reg - COUNT_W'(1);
    assign mid_wide = lo_reg + (span >> 1);
    assign mid_ext  = COUNT_W'(mid_reg);
    assign mid_plus = mid_ext + COUNT_W'(1);
    assign probe    = $signed(ram_rdata);

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = ADDR_W'(item.entry_position);
        ram_req.wdata = item.entry_or_key;
        ram_req.re    = 1'b0;
        ram_req.raddr = mid_wide[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.command == CMD_WRITE)
                    begin
                        ram_req.we = (COUNT_W'(item.entry_position) < COUNT_W'(TABLE_DEPTH));
                    end
                    else
                    begin
                        key_next = item.entry_or_key;
                        lo_next  = '0;
                        hi_next  = limit;
                        if (limit == '0)
                        begin
                            done_next   = 1'b1;
                            result_next = '0;
                        end
                        else
                        begin
                            state_next = ST_PROBE;
                        end
                    end
                end
            end
            ST_PROBE:
            begin
                ram_req.re = 1'b1;
                mid_next   = mid_wide[ADDR_W-1:0];
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                if (probe == key_reg)
                begin
                    done_next                  = 1'b1;
                    result_next.found          = 1'b1;
                    result_next.match_position = POS_W'(mid_reg);
                    state_next                 = ST_IDLE;
                end
                else if (probe < key_reg)
                begin
                    lo_next = mid_plus;
                    if (mid_plus >= hi_reg)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_PROBE;
                    end
                end
                else
                begin
                    hi_next = mid_ext;
                    if (lo_reg >= mid_ext)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_PROBE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        key_reg    <= key_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_window_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (lo_reg < hi_reg))
        else $error("probe issued on an empty window");

    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (hi_reg <= COUNT_W'(TABLE_DEPTH)))
        else $error("window runs past the table");

    a_compare_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |=> (state_reg == ST_COMPARE))
        else $error("compare did not follow probe");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE || (state_reg == ST_IDLE && !start)) |=> !done_reg)
        else $error("result strobe without a finished lookup");

    a_hit_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMPARE) |-> (mid_ext >= lo_reg && mid_ext < hi_reg))
        else $error("midpoint outside window");

endmodule

@@ src/sorted_table_binary_search_core.sv @@
// A write item gives no result and leaves the block free for the next item;
// a lookup gives its result after P probes (at most 11 for 1024 entries).
// Each probe is one table read plus a compare. busy is high while a lookup
// runs; results are a one-cycle done strobe that the receiver cannot stall.
// Reset (rst_n, async, low) clears the control state and entries_in_use;
// table contents stay undefined until written.
module sorted_table_binary_search_core
    import sbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  in_item_t           item,
    output logic               done,
    output out_item_t          result,
    input  logic               cfg_write,
    input  logic [COUNT_W-1:0] cfg_data
);

    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rdata;

    // Sequencer: take each item, run the halving loop over the table one
    // probe at a time, and register the result strobe.
    sbs_search_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // Table store: one write port for load items, one registered read port
    // for probes. Writes and probes never overlap, so no forwarding is needed.
    sbs_table_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

@@ tb/sorted_table_binary_search_core_tb.sv @@
`timescale 1ns / 100ps

module sorted_table_binary_search_core_tb
    import sbs_pkg::*;
();

    // Bounds of the signed entry range, used for the edge-of-range keys
    localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    // Largest register value; anything above TABLE_DEPTH searches the whole table
    localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;

    // A lookup of 1024 entries needs at most 11 probes; the drain wait leaves margin over it
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_ITEMS = 700;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    in_item_t           item      = '0;
    logic               done;
    out_item_t          result;
    logic               cfg_write = 1'b0;
    logic [COUNT_W-1:0] cfg_data  = '0;

    // Shadow copy of the table and of the searched-entry count
    logic signed [DATA_W-1:0] table_copy [TABLE_DEPTH];
    logic [COUNT_W-1:0]       entries_cfg = '0;

    // Answers still owed by the block, oldest first
    out_item_t search_answers [$];

    int  mismatch_count  = 0;
    int  answers_checked = 0;
    int  random_items    = 0;
    bit  gaps_on         = 1'b0;

    always #4 clk = ~clk;

    sorted_table_binary_search_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // Count a mismatch and print one line for it
    task automatic flag_mismatch(string what);
        mismatch_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Halve the window [lo, hi] over the first entries_cfg entries, exactly
    // as the block does; stop at the first equal entry the halving meets
    function automatic out_item_t search_table(logic signed [DATA_W-1:0] key);
        int        lo;
        int        hi;
        int        mid;
        out_item_t answer;
        answer = '0;
        lo     = 0;
        hi     = (entries_cfg > TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(entries_cfg) - 1;
        while (lo <= hi && !answer.found)
        begin
            mid = lo + (hi - lo) / 2;
            if (table_copy[mid] == key)
            begin
                answer.found          = 1'b1;
                answer.match_position = mid[POS_W-1:0];
            end
            else if (table_copy[mid] < key)
            begin
                lo = mid + 1;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        return answer;
    endfunction

    function automatic in_item_t make_write(int pos, logic signed [DATA_W-1:0] value);
        in_item_t it;
        it.command        = CMD_WRITE;
        it.entry_position = pos[POS_W-1:0];
        it.entry_or_key   = value;
        return it;
    endfunction

    // The position field is ignored for lookups; randomise it anyway so
    // that a block which wrongly uses it gets caught
    function automatic in_item_t make_lookup(logic signed [DATA_W-1:0] key);
        in_item_t it;
        it.command        = CMD_LOOKUP;
        it.entry_position = POS_W'($urandom);
        it.entry_or_key   = key;
        return it;
    endfunction

    // Choose a key for a table of n searched entries: mostly keys that are
    // present, then near misses, then anything at all and the range limits
    function automatic logic signed [DATA_W-1:0] pick_key(int n);
        int sel;
        int idx;
        sel = $urandom_range(0, 99);
        idx = (n > 0) ? $urandom_range(0, n - 1) : 0;
        if (n > 0 && sel < 55)
        begin
            return table_copy[idx];
        end
        if (n > 0 && sel < 75)
        begin
            return $urandom_range(0, 1) ? table_copy[idx] + 1 : table_copy[idx] - 1;
        end
        if (sel < 88)
        begin
            return $urandom;
        end
        return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
    endfunction

    // Present one item and hold it until the block takes it. start is left
    // high on return, so a following item goes out back to back; update the
    // shadow table or book the expected answer at the accepting edge.
    task automatic send_item(in_item_t it);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        if (it.command == CMD_WRITE)
        begin
            table_copy[it.entry_position] = it.entry_or_key;
        end
        else
        begin
            search_answers.push_back(search_table(it.entry_or_key));
        end
    endtask

    // Drop start, wait for every owed answer, then allow a write item
    // still in flight to land before anything touches the register
    task automatic wait_quiet();
        start <= 1'b0;
        while (search_answers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Only call with the block idle, i.e. straight after wait_quiet
    task automatic set_entries_in_use(int unsigned count);
        cfg_write <= 1'b1;
        cfg_data  <= count[COUNT_W-1:0];
        @(posedge clk);
        cfg_write   <= 1'b0;
        entries_cfg  = count[COUNT_W-1:0];
    endtask

    // Load positions 0..n-1 in ascending order, with dup_pct percent
    // repeated values; span_all pins the ends to the range limits
    task automatic load_sorted(int n, int dup_pct, bit span_all);
        longint                   value;
        longint                   step_max;
        logic signed [DATA_W-1:0] entry;
        case ($urandom_range(0, 3))
            0:       step_max = 1;
            1:       step_max = 7;
            2:       step_max = 4096;
            default: step_max = 1 << 20;
        endcase
        value = longint'(int'($urandom));
        if (value > 64'sd2147483647 - n * step_max)
        begin
            value = value - n * step_max - 1;
        end
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && $urandom_range(0, 99) >= dup_pct)
            begin
                value += $urandom_range(1, int'(step_max));
            end
            entry = value[DATA_W-1:0];
            if (span_all && i == 0)
            begin
                entry = KEY_MIN;
            end
            if (span_all && i == n - 1)
            begin
                entry = KEY_MAX;
            end
            send_item(make_write(i, entry));
        end
    endtask

    task automatic load_unsorted(int n);
        for (int i = 0; i < n; i++)
        begin
            send_item(make_write(i, $urandom));
        end
    endtask

    // Straight after reset the count is 0: nothing can be found
    task automatic test_empty_table();
        gaps_on = 1'b0;
        send_item(make_lookup(0));
        send_item(make_lookup(KEY_MIN));
        send_item(make_lookup(KEY_MAX));
        wait_quiet();
        set_entries_in_use(0);
        send_item(make_lookup($urandom));
        wait_quiet();
    endtask

    // Entries at both range limits, found and missed, with four entries
    // and with a single one
    task automatic test_range_limits();
        send_item(make_write(0, KEY_MIN));
        send_item(make_write(1, -1));
        send_item(make_write(2, 0));
        send_item(make_write(3, KEY_MAX));
        wait_quiet();
        set_entries_in_use(4);
        send_item(make_lookup(KEY_MIN));
        send_item(make_lookup(-1));
        send_item(make_lookup(0));
        send_item(make_lookup(KEY_MAX));
        send_item(make_lookup(1));
        send_item(make_lookup(KEY_MIN + 1));
        send_item(make_lookup(KEY_MAX - 1));
        wait_quiet();
        set_entries_in_use(1);
        send_item(make_lookup(KEY_MIN));
        send_item(make_lookup(0));
        wait_quiet();
    endtask

    // Runs of equal entries: the answer is whichever copy the halving hits
    task automatic test_duplicates();
        for (int i = 0; i < 7; i++)
        begin
            send_item(make_write(i, (i < 5) ? 5 : 9));
        end
        wait_quiet();
        set_entries_in_use(7);
        send_item(make_lookup(5));
        send_item(make_lookup(9));
        send_item(make_lookup(7));
        send_item(make_lookup(4));
        send_item(make_lookup(10));
        wait_quiet();
    endtask

    // Fill the whole table, search all of it, then check that counts
    // above the depth behave as the full depth
    task automatic test_full_table();
        gaps_on = 1'b1;
        load_sorted(TABLE_DEPTH, 10, 1'b1);
        wait_quiet();
        set_entries_in_use(TABLE_DEPTH);
        send_item(make_lookup(KEY_MIN));
        send_item(make_lookup(KEY_MAX));
        repeat (50) send_item(make_lookup(pick_key(TABLE_DEPTH)));
        wait_quiet();
        set_entries_in_use(TABLE_DEPTH + 1);
        send_item(make_lookup(KEY_MAX));
        repeat (10) send_item(make_lookup(pick_key(TABLE_DEPTH)));
        wait_quiet();
        set_entries_in_use(COUNT_MAX);
        send_item(make_lookup(KEY_MAX));
        send_item(make_lookup(KEY_MIN));
        repeat (10) send_item(make_lookup(pick_key(TABLE_DEPTH)));
        wait_quiet();
    endtask

    // Out-of-order entries: the block still halves, no error is expected
    task automatic test_unsorted_table();
        load_unsorted(20);
        wait_quiet();
        set_entries_in_use(20);
        repeat (30) send_item(make_lookup(pick_key(20)));
        wait_quiet();
    endtask

    // Phases of random count, fresh small tables and mixed lookups, with
    // stray writes that disturb the order now and then. Idling stops for
    // the last fifth of the run.
    task automatic test_random_phases();
        int unsigned count;
        int          searched;
        int          sel;
        while (random_items < RANDOM_ITEMS)
        begin
            gaps_on = (random_items < RANDOM_ITEMS * 4 / 5) && ($urandom_range(0, 3) != 0);
            sel     = $urandom_range(0, 99);
            if (sel < 10)
            begin
                count = 0;
            end
            else if (sel < 75)
            begin
                count = $urandom_range(1, 48);
            end
            else if (sel < 90)
            begin
                count = $urandom_range(49, TABLE_DEPTH);
            end
            else
            begin
                count = $urandom_range(TABLE_DEPTH + 1, COUNT_MAX);
            end
            searched = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
            wait_quiet();
            set_entries_in_use(count);
            // Reload only small tables; the rest of the table is already written
            if (searched > 0 && searched <= 48)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    load_unsorted(searched);
                end
                else
                begin
                    load_sorted(searched, $urandom_range(0, 40), $urandom_range(0, 5) == 0);
                end
                random_items += searched;
            end
            repeat ($urandom_range(12, 30))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(make_write($urandom_range(0, TABLE_DEPTH - 1), $urandom));
                end
                else
                begin
                    send_item(make_lookup(pick_key(searched)));
                end
                random_items++;
            end
        end
        wait_quiet();
    endtask

    // Compare each answer with the oldest one owed; the receiver has no
    // way to hold the strobe off, so look at every edge
    always @(posedge clk)
    begin : check_answers
        out_item_t owed;
        if (rst_n && done)
        begin
            if (search_answers.size() == 0)
            begin
                flag_mismatch("answer strobed with no lookup outstanding");
            end
            else
            begin
                owed = search_answers.pop_front();
                if (result.found !== owed.found)
                begin
                    flag_mismatch($sformatf("answer %0d: found %b, expected %b",
                                            answers_checked, result.found, owed.found));
                end
                if (result.match_position !== owed.match_position)
                begin
                    flag_mismatch($sformatf("answer %0d: match_position %0d, expected %0d",
                                            answers_checked, result.match_position,
                                            owed.match_position));
                end
                answers_checked++;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_table();
        test_range_limits();
        test_duplicates();
        test_full_table();
        test_unsorted_table();
        test_random_phases();

        wait_quiet();
        if (mismatch_count == 0 && search_answers.size() == 0)
        begin
            $display("** sorted_table_binary_search_core: PASSED **");
        end
        else
        begin
            $display("** sorted_table_binary_search_core: FAILED **");
        end
        $finish;
    end

    // Hang guard, far above the slowest correct run
    initial
    begin
        #8_000_000;
        $display("** sorted_table_binary_search_core: FAILED **");
        $finish;
    end

endmodule

@@ sorted_table_binary_search_core.f @@
src/sbs_pkg.sv
src/sbs_table_ram.sv
src/sbs_search_ctrl.sv
src/sorted_table_binary_search_core.sv
tb/sorted_table_binary_search_core_tb.sv
